### hdl/oebd_pkg.sv
package oebd_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int SLOT_W = $clog2(TABLE_ENTRIES);

	localparam logic [2:0] OP_ACCEPT    = 3'd0;
	localparam logic [2:0] OP_MODIFY    = 3'd1;
	localparam logic [2:0] OP_REPLACE   = 3'd2;
	localparam logic [2:0] OP_TERMINATE = 3'd3;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_MODIFY = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_ERASE,
		ST_INSERT,
		ST_EMIT_REM,
		ST_EMIT_MAIN
	} state_t;

	typedef struct packed {
		logic                valid;
		logic [63:0]         order;
		logic [31:0]         instrument;
		logic                side;
		logic signed [63:0]  price;
	} entry_t;

	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic scan_rd;
		logic erase;
		logic insert;
		logic load_rem;
		logic load_main;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic need_rem;
		logic need_ins;
		logic need_main;
		logic out_free;
	} status_t;

endpackage

### hdl/order_event_to_book_delta_top.sv
// Order events in, sequenced book deltas out. Each accepted event sweeps the
// whole order table in its memory, one entry per cycle through the single read
// port, so a new event is taken only after the previous one has swept the table
// and its zero, one or two deltas have gone into the output register, each once
// the output is free. After reset a clearing pass empties every table entry
// before the first event is taken; the sequence register may be written at any
// idle time.
module order_event_to_book_delta_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [63:0]  cfg_wr_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// order_key, prior_order_key, instrument, book_side, price_in, quantity_in
	input  logic [295:0] s_tdata,
	// opcode
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// instrument_out, sequence_res, order_out, side_out, price_out, quantity_out
	output logic [295:0] m_tdata,
	// delta_kind, table_full
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	oebd_pkg::cmd_t    cmd;
	oebd_pkg::status_t status;

	oebd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	oebd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

### hdl/oebd_ctrl.sv
module oebd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  oebd_pkg::status_t  status,
	output oebd_pkg::cmd_t     cmd
);

	oebd_pkg::state_t state_q;
	oebd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oebd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oebd_pkg::ST_CLEAR: begin
				if (status.idx_last) state_d = oebd_pkg::ST_IDLE;
			end
			oebd_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = oebd_pkg::ST_SCAN;
			end
			oebd_pkg::ST_SCAN: begin
				if (status.idx_last) state_d = oebd_pkg::ST_SCAN_END;
			end
			oebd_pkg::ST_SCAN_END: state_d = oebd_pkg::ST_ERASE;
			oebd_pkg::ST_ERASE:    state_d = oebd_pkg::ST_INSERT;
			oebd_pkg::ST_INSERT:   state_d = oebd_pkg::ST_EMIT_REM;
			oebd_pkg::ST_EMIT_REM: begin
				if (!status.need_rem || status.out_free) state_d = oebd_pkg::ST_EMIT_MAIN;
			end
			oebd_pkg::ST_EMIT_MAIN: begin
				if (!status.need_main || status.out_free) state_d = oebd_pkg::ST_IDLE;
			end
			default: state_d = oebd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			oebd_pkg::ST_CLEAR:     cmd.clear_wr = 1'b1;
			oebd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.capture = s_tvalid;
			end
			oebd_pkg::ST_SCAN:      cmd.scan_rd = 1'b1;
			oebd_pkg::ST_SCAN_END:  cmd = '0;
			oebd_pkg::ST_ERASE:     cmd.erase = status.need_rem;
			oebd_pkg::ST_INSERT:    cmd.insert = status.need_ins;
			oebd_pkg::ST_EMIT_REM:  cmd.load_rem = status.need_rem && status.out_free;
			oebd_pkg::ST_EMIT_MAIN: cmd.load_main = status.need_main && status.out_free;
			default:                cmd = '0;
		endcase
	end

endmodule

### hdl/oebd_dp.sv
module oebd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oebd_pkg::cmd_t              cmd,
	output oebd_pkg::status_t           status,
	input  logic [295:0]                s_tdata,
	input  logic [2:0]                  s_tuser,
	input  logic                        cfg_wr_en,
	input  logic [63:0]                 cfg_wr_data,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [295:0]                m_tdata,
	output logic [2:0]                  m_tuser,
	output logic                        m_tlast
);

	localparam int SW = oebd_pkg::SLOT_W;

	oebd_pkg::entry_t mem [oebd_pkg::TABLE_ENTRIES];
	oebd_pkg::entry_t rd_s1;
	logic             rd_v_s1;
	logic [SW-1:0]    rd_idx_s1;
	logic [SW-1:0]    idx_q;

	// Captured event.
	logic [2:0]         op_q;
	logic [63:0]        key_q;
	logic [63:0]        prior_q;
	logic [31:0]        inst_q;
	logic               side_q;
	logic signed [63:0] price_q;
	logic [63:0]        qty_q;
	logic               same_key_q;

	// Probe results.
	logic               pm_found_q;
	logic [SW-1:0]      pm_slot_q;
	logic [31:0]        pm_inst_q;
	logic               pm_side_q;
	logic signed [63:0] pm_price_q;
	logic [63:0]        pm_order_q;
	logic               km_found_q;
	logic [SW-1:0]      km_slot_q;
	logic               free_found_q;
	logic [SW-1:0]      free_slot_q;

	logic [63:0]        seq_q;
	logic               out_v_q;
	logic [295:0]       out_data_q;
	logic [2:0]         out_user_q;
	logic               out_last_q;

	logic [63:0]        probe_key;
	logic               hit_p;
	logic               hit_k;
	logic               free_c;
	logic               is_ins_op;
	logic               ins_ok;
	logic [SW-1:0]      ins_slot;
	logic               we;
	logic [SW-1:0]      waddr;
	oebd_pkg::entry_t   wdata;
	logic [295:0]       res_data;
	logic [2:0]         res_user;
	logic               res_last;

	assign probe_key = (op_q == oebd_pkg::OP_REPLACE) ? prior_q : key_q;
	assign hit_p  = rd_v_s1 && rd_s1.valid && (rd_s1.order == probe_key);
	// On a replace with the same id the old entry is freed first, so it cannot match.
	assign hit_k  = rd_v_s1 && rd_s1.valid && (rd_s1.order == key_q) &&
			!((op_q == oebd_pkg::OP_REPLACE) && same_key_q);
	assign free_c = rd_v_s1 && (!rd_s1.valid || ((op_q == oebd_pkg::OP_REPLACE) && hit_p));

	assign is_ins_op = (op_q == oebd_pkg::OP_ACCEPT) || (op_q == oebd_pkg::OP_REPLACE);
	assign ins_ok    = km_found_q || free_found_q;
	assign ins_slot  = km_found_q ? km_slot_q : free_slot_q;

	assign status.idx_last  = (idx_q == SW'(oebd_pkg::TABLE_ENTRIES - 1));
	assign status.need_rem  = pm_found_q &&
			((op_q == oebd_pkg::OP_REPLACE) || (op_q == oebd_pkg::OP_TERMINATE));
	assign status.need_ins  = is_ins_op && ins_ok;
	assign status.need_main = is_ins_op || ((op_q == oebd_pkg::OP_MODIFY) && pm_found_q);
	assign status.out_free  = !out_v_q || m_tready;

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		if (cmd.clear_wr) begin
			we = 1'b1;
		end else if (cmd.erase) begin
			we = 1'b1;
			waddr = pm_slot_q;
		end else if (cmd.insert) begin
			we = 1'b1;
			waddr = ins_slot;
			wdata.valid = 1'b1;
			wdata.order = key_q;
			wdata.instrument = inst_q;
			wdata.side = side_q;
			wdata.price = price_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[idx_q];
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_rd;
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.clear_wr || cmd.scan_rd) begin
				idx_q <= status.idx_last ? '0 : idx_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= s_tuser;
			key_q      <= s_tdata[63:0];
			prior_q    <= s_tdata[127:64];
			inst_q     <= s_tdata[159:128];
			side_q     <= s_tdata[160];
			price_q    <= s_tdata[224:161];
			qty_q      <= s_tdata[288:225];
			same_key_q <= (s_tdata[63:0] == s_tdata[127:64]);
		end
		if (hit_p && !pm_found_q) begin
			pm_slot_q  <= rd_idx_s1;
			pm_inst_q  <= rd_s1.instrument;
			pm_side_q  <= rd_s1.side;
			pm_price_q <= rd_s1.price;
			pm_order_q <= rd_s1.order;
		end
		if (hit_k && !km_found_q) km_slot_q <= rd_idx_s1;
		if (free_c && !free_found_q) free_slot_q <= rd_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_found_q   <= 1'b0;
			km_found_q   <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.capture) begin
			pm_found_q   <= 1'b0;
			km_found_q   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (hit_p)  pm_found_q   <= 1'b1;
			if (hit_k)  km_found_q   <= 1'b1;
			if (free_c) free_found_q <= 1'b1;
		end
	end

	always_comb begin
		res_data = '0;
		res_user = '0;
		res_last = 1'b1;
		res_data[95:32] = seq_q;
		if (cmd.load_rem) begin
			res_data[31:0]    = pm_inst_q;
			res_data[159:96]  = pm_order_q;
			res_data[160]     = pm_side_q;
			res_data[224:161] = pm_price_q;
			res_user[1:0]     = oebd_pkg::KIND_REMOVE;
			res_last          = (op_q == oebd_pkg::OP_TERMINATE);
		end else if (op_q == oebd_pkg::OP_MODIFY) begin
			res_data[31:0]    = pm_inst_q;
			res_data[159:96]  = key_q;
			res_data[160]     = pm_side_q;
			res_data[224:161] = pm_price_q;
			res_data[288:225] = qty_q;
			res_user[1:0]     = oebd_pkg::KIND_MODIFY;
		end else begin
			res_data[31:0]    = inst_q;
			res_data[159:96]  = key_q;
			res_data[160]     = side_q;
			res_data[224:161] = price_q;
			res_data[288:225] = qty_q;
			res_user[1:0]     = oebd_pkg::KIND_ADD;
			res_user[2]       = !ins_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seq_q <= cfg_wr_data;
			end else if (cmd.load_rem || cmd.load_main) begin
				seq_q <= seq_q + 64'd1;
			end
			if (cmd.load_rem || cmd.load_main) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rem || cmd.load_main) begin
			out_data_q <= res_data;
			out_user_q <= res_user;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule
